// ===== rtl/alpt_pkg.sv =====
package alpt_pkg;

    // coordinate width of block positions and partition corner
    localparam int POS_BITS = 31;

    // signed coordinate differences
    localparam int DIFF_W = POS_BITS + 1;
    // skew magnitude and gap step counts
    localparam int SKEW_W = DIFF_W + 1;
    localparam int GAP_W = DIFF_W + 2;
    // products
    localparam int MPROD_W = DIFF_W + 9;
    localparam int GPROD_W = GAP_W + 9;
    // width of the bound and guaranteed sums, wide enough to stay exact
    localparam int SUM_W = (POS_BITS + 16 > 50) ? POS_BITS + 16 : 50;

    localparam int SCORE_W = 32;
    localparam int BEST_W = 48;
    localparam logic signed [BEST_W-1:0] BEST_MIN = {1'b1, {(BEST_W-1){1'b0}}};
    localparam logic signed [BEST_W-1:0] BEST_MAX = {1'b0, {(BEST_W-1){1'b1}}};

    localparam int IN_FIELDS_W = 4 * POS_BITS + 2 * SCORE_W;
    localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_USER_W = 8;
    localparam int OUT_FIELDS_W = 1 + BEST_W;
    localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = (POS_BITS > 32) ? POS_BITS : 32;

    // pipeline depth, input register through result register
    localparam int NSTG = 7;
    localparam int CNT_W = $clog2(NSTG + 1) + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CORNER_ROW = 8'd0,
        REG_CORNER_COL = 8'd1,
        REG_MATCH_BONUS = 8'd2,
        REG_MISMATCH = 8'd3,
        REG_GAP_OPEN = 8'd4,
        REG_GAP_EXTEND = 8'd5,
        REG_GLOBAL_MODE = 8'd6
    } cfg_reg_t;

    typedef enum logic {
        ACT_TEST = 1'b0,
        ACT_RESTART = 1'b1
    } action_t;

endpackage

// ===== rtl/alignment_block_pruning_test.sv =====
// block pruning test, seven-register pipeline from input register to result register
// a result shows on m_tvalid once its item has passed through the stage registers into the result register
// throughput: one item per cycle; each stage holds only while the stage after it is full
// and stalled; the kept best score is a single compare and select in the last stage
// reset: synchronous active-low aresetn empties the pipeline, loads the register
// defaults and sets the kept best score to the most negative 48-bit value
module alignment_block_pruning_test import alpt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // fields from bit 0: row_start, col_start, row_end, col_end, bound_adjust,
    // corner_score, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // fields from bit 0: action, block_missing, zero fill
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // fields from bit 0: prunable, best_now, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STG_OUT = NSTG - 1;

    // configuration
    logic [POS_BITS-1:0]     corner_row_reg;
    logic [POS_BITS-1:0]     corner_col_reg;
    logic signed [8:0]       match_reg;
    logic signed [8:0]       mismatch_reg;
    logic [7:0]              open_cost_reg;
    logic [7:0]              gap_ext_reg;
    logic                    global_reg;

    // flow control
    logic [NSTG-1:0]         vld_reg;
    logic [NSTG-1:0]         rdy;

    // stage 1: input register
    logic                    act1_reg, miss1_reg;
    logic [POS_BITS-1:0]     r0_reg, c0_reg, r1_reg, c1_reg;
    logic signed [SCORE_W-1:0] adj1_reg, score1_reg;
    // stage 2: differences
    logic                    act2_reg, miss2_reg;
    logic signed [DIFF_W-1:0] dr_reg, dc_reg, sr_reg, sc_reg;
    logic signed [SCORE_W-1:0] adj2_reg, score2_reg;
    // stage 3: min, span, skew
    logic                    act3_reg, miss3_reg;
    logic signed [DIFF_W-1:0] dmin3_reg, span_reg;
    logic signed [SKEW_W:0]  skew_reg;
    logic signed [SCORE_W-1:0] adj3_reg, score3_reg;
    // stage 4: gap step counts
    logic                    act4_reg, miss4_reg;
    logic signed [DIFF_W-1:0] dmin4_reg;
    logic signed [GAP_W-1:0] g_reg, gsum_reg;
    logic signed [SCORE_W-1:0] adj4_reg, score4_reg;
    // stage 5: products
    logic                    act5_reg, miss5_reg, gpos5_reg;
    logic signed [MPROD_W-1:0] incm_reg, mm_reg;
    logic signed [GPROD_W-1:0] gext_reg, sext_reg;
    logic signed [SCORE_W-1:0] adj5_reg, score5_reg;
    // stage 6: bound and guaranteed score
    logic                    act6_reg, miss6_reg;
    logic signed [SUM_W-1:0] bound_reg;
    logic signed [BEST_W-1:0] guar_reg;
    // stage 7: result
    logic                    prune_reg;
    logic signed [BEST_W-1:0] best_reg;

    logic signed [DIFF_W-1:0] dr_next, dc_next, sr_next, sc_next;
    logic signed [DIFF_W-1:0] dmin_next, span_next;
    logic signed [SKEW_W-1:0] diff_next;
    logic signed [SKEW_W:0]  skew_next;
    logic signed [GAP_W-1:0] g_next, gsum_next;
    logic signed [MPROD_W-1:0] incm_next, mm_next;
    logic signed [GPROD_W-1:0] gext_next, sext_next;
    logic signed [SUM_W-1:0] open_w, inc_w, dec_w, gdiff_w, bound_next;
    logic signed [BEST_W-1:0] guar_next;
    logic signed [BEST_W-1:0] best_next;
    logic                    prune_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_row_reg <= '0;
            corner_col_reg <= '0;
            match_reg <= 9'sd1;
            mismatch_reg <= -9'sd3;
            open_cost_reg <= 8'd3;
            gap_ext_reg <= 8'd2;
            global_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_CORNER_ROW: corner_row_reg <= cfg_data[POS_BITS-1:0];
                REG_CORNER_COL: corner_col_reg <= cfg_data[POS_BITS-1:0];
                REG_MATCH_BONUS: match_reg <= cfg_data[8:0];
                REG_MISMATCH: mismatch_reg <= cfg_data[8:0];
                REG_GAP_OPEN: open_cost_reg <= cfg_data[7:0];
                REG_GAP_EXTEND: gap_ext_reg <= cfg_data[7:0];
                REG_GLOBAL_MODE: global_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // a stage takes a new item when it is empty or its successor moves on
    always_comb begin
        rdy[STG_OUT] = !vld_reg[STG_OUT] || m_tready;
        for (int k = STG_OUT - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[STG_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            act1_reg <= s_tuser[0];
            miss1_reg <= s_tuser[1];
            r0_reg <= s_tdata[POS_BITS-1:0];
            c0_reg <= s_tdata[2*POS_BITS-1:POS_BITS];
            r1_reg <= s_tdata[3*POS_BITS-1:2*POS_BITS];
            c1_reg <= s_tdata[4*POS_BITS-1:3*POS_BITS];
            adj1_reg <= s_tdata[4*POS_BITS+SCORE_W-1:4*POS_BITS];
            score1_reg <= s_tdata[4*POS_BITS+2*SCORE_W-1:4*POS_BITS+SCORE_W];
        end
    end

    // stage 2
    always_comb begin
        dr_next = $signed({1'b0, corner_row_reg}) - $signed({1'b0, r0_reg});
        dc_next = $signed({1'b0, corner_col_reg}) - $signed({1'b0, c0_reg});
        sr_next = $signed({1'b0, r1_reg}) - $signed({1'b0, r0_reg});
        sc_next = $signed({1'b0, c1_reg}) - $signed({1'b0, c0_reg});
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            act2_reg <= act1_reg;
            miss2_reg <= miss1_reg;
            dr_reg <= dr_next;
            dc_reg <= dc_next;
            sr_reg <= sr_next;
            sc_reg <= sc_next;
            adj2_reg <= adj1_reg;
            score2_reg <= score1_reg;
        end
    end

    // stage 3
    always_comb begin
        dmin_next = (dr_reg < dc_reg) ? dr_reg : dc_reg;
        span_next = (sc_reg > sr_reg) ? sc_reg : sr_reg;
        diff_next = SKEW_W'(dc_reg) - SKEW_W'(dr_reg);
        skew_next = (diff_next < 0) ? -(SKEW_W + 1)'(diff_next) : (SKEW_W + 1)'(diff_next);
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            act3_reg <= act2_reg;
            miss3_reg <= miss2_reg;
            dmin3_reg <= dmin_next;
            span_reg <= span_next;
            skew_reg <= skew_next;
            adj3_reg <= adj2_reg;
            score3_reg <= score2_reg;
        end
    end

    // stage 4
    always_comb begin
        g_next = GAP_W'(skew_reg) - GAP_W'(span_reg);
        gsum_next = GAP_W'(skew_reg) + GAP_W'(span_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            act4_reg <= act3_reg;
            miss4_reg <= miss3_reg;
            dmin4_reg <= dmin3_reg;
            g_reg <= g_next;
            gsum_reg <= gsum_next;
            adj4_reg <= adj3_reg;
            score4_reg <= score3_reg;
        end
    end

    // stage 5
    always_comb begin
        incm_next = MPROD_W'(dmin4_reg) * MPROD_W'(match_reg);
        mm_next = MPROD_W'(dmin4_reg) * MPROD_W'(mismatch_reg);
        gext_next = GPROD_W'(g_reg) * GPROD_W'($signed({1'b0, gap_ext_reg}));
        sext_next = GPROD_W'(gsum_reg) * GPROD_W'($signed({1'b0, gap_ext_reg}));
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            act5_reg <= act4_reg;
            miss5_reg <= miss4_reg;
            gpos5_reg <= (g_reg > 0);
            incm_reg <= incm_next;
            mm_reg <= mm_next;
            gext_reg <= gext_next;
            sext_reg <= sext_next;
            adj5_reg <= adj4_reg;
            score5_reg <= score4_reg;
        end
    end

    // stage 6
    always_comb begin
        open_w = SUM_W'($signed({1'b0, open_cost_reg}));
        inc_w = SUM_W'(incm_reg);
        dec_w = '0;
        if (global_reg) begin
            if (gpos5_reg) begin
                inc_w = SUM_W'(incm_reg) - open_w - SUM_W'(gext_reg);
            end
            dec_w = open_w + SUM_W'(sext_reg) - SUM_W'(mm_reg);
        end
        gdiff_w = SUM_W'(score5_reg) - dec_w;
        if (gdiff_w > SUM_W'(BEST_MAX)) begin
            guar_next = BEST_MAX;
        end else if (gdiff_w < SUM_W'(BEST_MIN)) begin
            guar_next = BEST_MIN;
        end else begin
            guar_next = gdiff_w[BEST_W-1:0];
        end
        bound_next = SUM_W'(score5_reg) + inc_w + SUM_W'(adj5_reg);
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            act6_reg <= act5_reg;
            miss6_reg <= miss5_reg;
            guar_reg <= guar_next;
            bound_reg <= bound_next;
        end
    end

    // stage 7: kept best score and prune decision
    always_comb begin
        best_next = best_reg;
        prune_next = 1'b0;
        if (action_t'(act6_reg) == ACT_RESTART) begin
            best_next = BEST_MIN;
        end else if (miss6_reg) begin
            prune_next = 1'b1;
        end else begin
            if (best_reg < guar_reg) begin
                best_next = guar_reg;
            end
            prune_next = (bound_reg <= SUM_W'(best_next));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg <= BEST_MIN;
        end else if (rdy[STG_OUT] && vld_reg[STG_OUT-1]) begin
            best_reg <= best_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[STG_OUT]) begin
            prune_reg <= prune_next;
        end
    end

    assign m_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, best_reg, prune_reg};

endmodule

// ===== rtl/alpt_checker.sv =====
module alpt_checker import alpt_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready
);

    logic [CNT_W-1:0]         cnt_reg;
    logic signed [BEST_W-1:0] prev_best_reg;
    logic                     in_acc, out_acc;
    logic signed [BEST_W-1:0] best_now;

    assign in_acc = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;
    assign best_now = m_tdata[BEST_W:1];

    // items in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (in_acc && !out_acc) begin
            cnt_reg <= cnt_reg + 1'b1;
        end else if (out_acc && !in_acc) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_best_reg <= BEST_MIN;
        end else if (out_acc) begin
            prev_best_reg <= best_now;
        end
    end

    // no result without an item behind it
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> cnt_reg != '0)
        else $error("result shown with no item in flight");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(NSTG))
        else $error("more items in flight than pipeline stages");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // the kept best only falls on a restart, back to the floor
    a_best_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> (best_now >= prev_best_reg) || (best_now == BEST_MIN))
        else $error("kept best score decreased");

endmodule

bind alignment_block_pruning_test alpt_checker u_alpt_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
);
